### rtl/core/etu_pkg.sv
// Shared types, character codes and token kind codes for the expression tokenizer.
`timescale 1ns / 1ps

package etu_pkg;

	localparam int POSITION_WIDTH_DEF = 16;
	localparam int MANTISSA_WIDTH_DEF = 32;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 5;
	localparam int FRAC_W = 4;
	localparam int USER_W = KIND_W + 1;

	// character codes
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

	// token kinds
	localparam logic [KIND_W-1:0] K_NUM     = 5'd0;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd2;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd3;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd4;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd5;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd6;
	localparam logic [KIND_W-1:0] K_EQEQ    = 5'd7;
	localparam logic [KIND_W-1:0] K_GT      = 5'd8;
	localparam logic [KIND_W-1:0] K_LT      = 5'd9;
	localparam logic [KIND_W-1:0] K_GE      = 5'd10;
	localparam logic [KIND_W-1:0] K_LE      = 5'd11;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd12;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd13;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd14;
	localparam logic [KIND_W-1:0] K_PUNCT   = 5'd15;
	localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd16;
	localparam logic [KIND_W-1:0] K_END     = 5'd17;

	// lexer step commands
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_PROC = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	typedef struct packed {
		logic [1:0]        code;
		logic [CHAR_W-1:0] h;
		logic              has_next;
		logic [CHAR_W-1:0] nx;
	} op_t;

	typedef struct packed {
		logic              digit;
		logic              ident;
		logic              ws;
		logic              lf;
		logic              dot;
		logic              eq;
		logic              lt;
		logic              cmp_lead;
		logic [KIND_W-1:0] single_kind;
	} class_t;

endpackage

### rtl/core/etu_class.sv
// Character classifier: character classes and single-character token kind.
`timescale 1ns / 1ps

module etu_class (
	input  logic [etu_pkg::CHAR_W-1:0] c,
	output etu_pkg::class_t            cls
);
	import etu_pkg::*;

	always_comb begin
		cls.digit    = (c >= CH_ZERO) && (c <= CH_NINE);
		cls.ident    = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
			|| cls.digit || (c == CH_USCORE);
		cls.ws       = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
		cls.lf       = (c == CH_LF);
		cls.dot      = (c == CH_DOT);
		cls.eq       = (c == CH_EQ);
		cls.lt       = (c == CH_LT);
		cls.cmp_lead = (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
		unique case (c) inside
			CH_PLUS:   cls.single_kind = K_PLUS;
			CH_MINUS:  cls.single_kind = K_MINUS;
			CH_STAR:   cls.single_kind = K_STAR;
			CH_SLASH:  cls.single_kind = K_SLASH;
			CH_EQ:     cls.single_kind = K_ASSIGN;
			CH_LT:     cls.single_kind = K_LT;
			CH_GT:     cls.single_kind = K_GT;
			CH_LPAREN: cls.single_kind = K_LPAREN;
			CH_RPAREN: cls.single_kind = K_RPAREN;
			CH_SEMI:   cls.single_kind = K_SEMI;
			CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_COMMA:
				cls.single_kind = K_PUNCT;
			default:   cls.single_kind = K_UNKNOWN;
		endcase
	end

endmodule

### rtl/core/etu_lexer.sv
// Token state and one-character classify-and-update step.
`timescale 1ns / 1ps

module etu_lexer #(
	parameter int POSITION_WIDTH = etu_pkg::POSITION_WIDTH_DEF,
	parameter int MANTISSA_WIDTH = etu_pkg::MANTISSA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  etu_pkg::op_t                op,
	output logic                        res_valid,
	output logic [etu_pkg::CHAR_W-1:0]  res_char,
	output logic [etu_pkg::KIND_W-1:0]  res_kind,
	output logic                        res_first,
	output logic                        res_last,
	output logic [POSITION_WIDTH-1:0]   res_line,
	output logic [POSITION_WIDTH-1:0]   res_col,
	output logic [POSITION_WIDTH-1:0]   res_len,
	output logic [MANTISSA_WIDTH-1:0]   res_mant,
	output logic [etu_pkg::FRAC_W-1:0]  res_frac,
	output logic                        res_ovf
);
	import etu_pkg::*;

	localparam int WIDE_W = MANTISSA_WIDTH + 4;

	logic [KIND_W-1:0]         kind_q, kind_n;
	logic                      inside_q, inside_n;
	logic                      cmp_q, cmp_n;
	logic [1:0]                dots_q, dots_n;
	logic [MANTISSA_WIDTH-1:0] mant_q, mant_n;
	logic [FRAC_W-1:0]         frac_q, frac_n;
	logic                      sat_q, sat_n;
	logic [POSITION_WIDTH-1:0] line_q, line_n;
	logic [POSITION_WIDTH-1:0] col_q, col_n;
	logic [POSITION_WIDTH-1:0] start_q, start_n;
	logic [POSITION_WIDTH-1:0] len_q, len_n;

	class_t hc, nc;

	etu_class u_class_h (.c(op.h),  .cls(hc));
	etu_class u_class_n (.c(op.nx), .cls(nc));

	// run path: base values are cleared when a number or identifier starts
	logic [KIND_W-1:0]         run_kind;
	logic [1:0]                b_dots, nu_dots;
	logic [MANTISSA_WIDTH-1:0] b_mant, nu_mant;
	logic [FRAC_W-1:0]         b_frac, nu_frac;
	logic                      b_sat, nu_sat;
	logic [POSITION_WIDTH-1:0] b_len;
	logic [WIDE_W-1:0]         wide;

	always_comb begin
		run_kind = inside_q ? kind_q : (hc.digit ? K_NUM : K_IDENT);
		b_dots   = inside_q ? dots_q : 2'd0;
		b_mant   = inside_q ? mant_q : '0;
		b_frac   = inside_q ? frac_q : '0;
		b_sat    = inside_q ? sat_q  : 1'b0;
		b_len    = inside_q ? len_q  : '0;
		// m*10 + digit; saturate when it leaves the mantissa range
		wide     = (WIDE_W'(b_mant) << 3) + (WIDE_W'(b_mant) << 1) + WIDE_W'(op.h[3:0]);
		nu_dots  = b_dots;
		nu_mant  = b_mant;
		nu_frac  = b_frac;
		nu_sat   = b_sat;
		if (hc.dot) begin
			if (b_dots != 2'd2)
				nu_dots = b_dots + 2'd1;
		end else if (hc.digit && (b_dots != 2'd2)) begin
			if (wide[WIDE_W-1:MANTISSA_WIDTH] != '0) begin
				nu_mant = '1;
				nu_sat  = 1'b1;
			end else begin
				nu_mant = wide[MANTISSA_WIDTH-1:0];
			end
			if ((b_dots == 2'd1) && (b_frac != '1))
				nu_frac = b_frac + 1'b1;
		end
	end

	always_comb begin
		kind_n    = kind_q;
		inside_n  = inside_q;
		cmp_n     = cmp_q;
		dots_n    = dots_q;
		mant_n    = mant_q;
		frac_n    = frac_q;
		sat_n     = sat_q;
		line_n    = line_q;
		col_n     = col_q;
		start_n   = start_q;
		len_n     = len_q;
		res_valid = 1'b0;
		res_char  = op.h;
		res_first = 1'b0;
		res_last  = 1'b0;
		res_line  = line_q;
		unique case (op.code)
			OP_PROC: begin
				if (cmp_q) begin
					// '=' that closes a two-character comparison
					cmp_n     = 1'b0;
					len_n     = (len_q != '1) ? len_q + 1'b1 : len_q;
					res_valid = 1'b1;
					res_last  = 1'b1;
				end else if (!inside_q && hc.ws) begin
					res_valid = 1'b0;
				end else if (!inside_q && hc.cmp_lead && op.has_next && nc.eq) begin
					kind_n    = hc.eq ? K_EQEQ : (hc.lt ? K_LE : K_GE);
					cmp_n     = 1'b1;
					start_n   = col_q;
					len_n     = POSITION_WIDTH'(1);
					res_valid = 1'b1;
					res_first = 1'b1;
				end else if (!inside_q && !hc.digit && !hc.ident) begin
					kind_n    = hc.single_kind;
					start_n   = col_q;
					len_n     = POSITION_WIDTH'(1);
					res_valid = 1'b1;
					res_first = 1'b1;
					res_last  = 1'b1;
				end else begin
					kind_n = run_kind;
					if (!inside_q)
						start_n = col_q;
					if (run_kind == K_NUM) begin
						dots_n = nu_dots;
						mant_n = nu_mant;
						frac_n = nu_frac;
						sat_n  = nu_sat;
					end
					len_n     = (b_len != '1) ? b_len + 1'b1 : b_len;
					res_last  = !(op.has_next && ((run_kind == K_NUM) ? (nc.digit || nc.dot)
						: nc.ident));
					inside_n  = !res_last;
					res_valid = 1'b1;
					res_first = !inside_q;
				end
				if (hc.lf) begin
					line_n = (line_q != '1) ? line_q + 1'b1 : line_q;
					col_n  = '0;
				end else begin
					col_n  = (col_q != '1) ? col_q + 1'b1 : col_q;
				end
			end
			OP_END: begin
				res_valid = 1'b1;
				res_char  = '0;
				res_first = 1'b1;
				res_last  = 1'b1;
				kind_n    = '0;
				inside_n  = 1'b0;
				cmp_n     = 1'b0;
				dots_n    = '0;
				mant_n    = '0;
				frac_n    = '0;
				sat_n     = 1'b0;
				line_n    = '0;
				col_n     = '0;
				start_n   = '0;
				len_n     = '0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// end token reports current column and zero length
	always_comb begin
		if (op.code == OP_END) begin
			res_kind = K_END;
			res_col  = col_q;
			res_len  = '0;
		end else begin
			res_kind = kind_n;
			res_col  = start_n;
			res_len  = len_n;
		end
		res_mant = (res_kind == K_NUM) ? mant_n : '0;
		res_frac = (res_kind == K_NUM) ? frac_n : '0;
		res_ovf  = (res_kind == K_NUM) && sat_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			inside_q <= 1'b0;
			cmp_q    <= 1'b0;
			dots_q   <= '0;
			mant_q   <= '0;
			frac_q   <= '0;
			sat_q    <= 1'b0;
			line_q   <= '0;
			col_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
		end else if (step_en) begin
			kind_q   <= kind_n;
			inside_q <= inside_n;
			cmp_q    <= cmp_n;
			dots_q   <= dots_n;
			mant_q   <= mant_n;
			frac_q   <= frac_n;
			sat_q    <= sat_n;
			line_q   <= line_n;
			col_q    <= col_n;
			start_q  <= start_n;
			len_q    <= len_n;
		end
	end

endmodule

### rtl/core/expression_tokenizer_unit.sv
// Streaming expression tokenizer top level: input register, step sequencer, result register.
// A byte's word is registered when its follower is in the input register and the lexer steps; for
// a tlast byte its own word and then the end token come from the extra lexer steps.
// Throughput: one byte per cycle unless stalled; a tlast byte takes three lexer steps, stalling
// the input for the extra steps. A stalled result register (m_axis_tready low) stalls the lexer.
// arst_n clears all control and token state; position counts restart at line 0, column 0.
`timescale 1ns / 1ps

module expression_tokenizer_unit #(
	parameter int POSITION_WIDTH = etu_pkg::POSITION_WIDTH_DEF,
	parameter int MANTISSA_WIDTH = etu_pkg::MANTISSA_WIDTH_DEF,
	localparam int RAW_W  = etu_pkg::CHAR_W + 3 * POSITION_WIDTH + MANTISSA_WIDTH
		+ etu_pkg::FRAC_W + 1,
	localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [etu_pkg::CHAR_W-1:0]  s_axis_tdata,  // character
	input  logic                        s_axis_tlast,  // last_of_text
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// character_res, line_number, column_number, token_length, mantissa,
	// fraction_digits, value_overflow, zero pad
	output logic [DATA_W-1:0]           m_axis_tdata,
	output logic [etu_pkg::USER_W-1:0]  m_axis_tuser,  // token_type, token_first
	output logic                        m_axis_tlast   // token_last
);
	import etu_pkg::*;

	localparam logic [1:0] PH_HELD = 2'd0;
	localparam logic [1:0] PH_LAST = 2'd1;
	localparam logic [1:0] PH_END  = 2'd2;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic [1:0]        phase_q;
	logic [CHAR_W-1:0] held_q;
	logic              held_valid_q;

	logic              out_valid_q;
	logic [RAW_W-1:0]  data_q;
	logic [USER_W-1:0] user_q;
	logic              tlast_q;

	logic adv;
	logic done;
	op_t  op;

	logic                      res_valid;
	logic [CHAR_W-1:0]         res_char;
	logic [KIND_W-1:0]         res_kind;
	logic                      res_first;
	logic                      res_last;
	logic [POSITION_WIDTH-1:0] res_line;
	logic [POSITION_WIDTH-1:0] res_col;
	logic [POSITION_WIDTH-1:0] res_len;
	logic [MANTISSA_WIDTH-1:0] res_mant;
	logic [FRAC_W-1:0]         res_frac;
	logic                      res_ovf;

	assign adv  = valid_s1 && (!out_valid_q || m_axis_tready);
	assign done = adv && (((phase_q == PH_HELD) && !last_s1) || (phase_q == PH_END));
	assign s_axis_tready = !valid_s1 || done;

	always_comb begin
		op.h        = char_s1;
		op.has_next = 1'b0;
		op.nx       = char_s1;
		unique case (phase_q)
			PH_HELD: begin
				op.code     = held_valid_q ? OP_PROC : OP_NONE;
				op.h        = held_q;
				op.has_next = 1'b1;
			end
			PH_LAST: op.code = OP_PROC;
			PH_END:  op.code = OP_END;
			default: op.code = OP_NONE;
		endcase
	end

	etu_lexer #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.MANTISSA_WIDTH(MANTISSA_WIDTH)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (adv),
		.op       (op),
		.res_valid(res_valid),
		.res_char (res_char),
		.res_kind (res_kind),
		.res_first(res_first),
		.res_last (res_last),
		.res_line (res_line),
		.res_col  (res_col),
		.res_len  (res_len),
		.res_mant (res_mant),
		.res_frac (res_frac),
		.res_ovf  (res_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			phase_q      <= PH_HELD;
			held_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				phase_q  <= PH_HELD;
			end else if (adv) begin
				// only the tlast byte walks through the extra steps
				unique case (phase_q)
					PH_HELD: phase_q <= PH_LAST;
					PH_LAST: phase_q <= PH_END;
					default: phase_q <= PH_HELD;
				endcase
			end
			if (adv && (phase_q == PH_HELD) && !last_s1)
				held_valid_q <= 1'b1;
			else if (adv && (phase_q == PH_END))
				held_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv && (phase_q == PH_HELD) && !last_s1)
			held_q <= char_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= res_valid;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			data_q  <= {res_ovf, res_frac, res_mant, res_len, res_col, res_line, res_char};
			user_q  <= {res_first, res_kind};
			tlast_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(data_q);
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = tlast_q;

endmodule
